FILE: rtl/i128div_pkg.sv
// Shared types and constants for the 128-bit signed/unsigned divider.
// No dependencies; imported by the controller, the datapath and the top level.
package i128div_pkg;

	localparam int WIDTH  = 128;
	localparam int HALF   = WIDTH / 2;
	localparam int CNT_W  = $clog2(WIDTH);
	localparam int DATA_W = 2 * WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABS,
		ST_ITER,
		ST_FIX
	} state_t;

	// One command bit per datapath operation; at most one is set in a cycle.
	typedef struct packed {
		logic load;
		logic absval;
		logic step;
		logic fix;
	} dp_cmd_t;

endpackage

FILE: rtl/i128div_ctrl.sv
// Controller for the 128-bit divider: sequences load, magnitude, 128 divide
// steps and sign fix-up. Depends on i128div_pkg.
module i128div_ctrl
	import i128div_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t           state_q;
	state_t           state_next;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_step;

	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (cnt_q == CNT_W'(WIDTH - 1));

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid)  state_next = ST_ABS;
			ST_ABS:  state_next = ST_ITER;
			ST_ITER: if (last_step) state_next = ST_FIX;
			ST_FIX:  if (out_free)  state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ABS:  cmd.absval = 1'b1;
			ST_ITER: cmd.step   = 1'b1;
			ST_FIX:  cmd.fix    = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.absval) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.fix) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/i128div_dp.sv
// Datapath for the 128-bit divider: operand registers, restoring
// shift-subtract step, sign handling and output register. Depends on i128div_pkg.
module i128div_dp
	import i128div_pkg::*;
(
	input  logic             clk,
	input  dp_cmd_t          cmd,
	input  logic             in_signed,
	input  logic [WIDTH-1:0] in_dividend,
	input  logic [WIDTH-1:0] in_divisor,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output logic             div_zero
);

	logic [WIDTH-1:0] num_q;   // dividend, shifted out as quotient bits shift in
	logic [WIDTH-1:0] den_q;
	logic [WIDTH-1:0] rem_q;
	logic             sgn_q;
	logic             neg_n_q;
	logic             neg_d_q;
	logic             dz_q;
	logic [WIDTH-1:0] quo_out_q;
	logic [WIDTH-1:0] rem_out_q;
	logic             dz_out_q;

	logic [WIDTH:0]   partial;
	logic [WIDTH:0]   diff;
	logic             fits;
	logic             neg_q_res;

	assign partial   = {rem_q, num_q[WIDTH-1]};
	assign diff      = partial - {1'b0, den_q};
	assign fits      = !diff[WIDTH];
	// A zero divisor leaves the all-ones quotient unsigned.
	assign neg_q_res = (neg_n_q ^ neg_d_q) && !dz_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= in_dividend;
			den_q <= in_divisor;
			sgn_q <= in_signed;
			dz_q  <= (in_divisor == '0);
		end
		if (cmd.absval) begin
			neg_n_q <= sgn_q && num_q[WIDTH-1];
			neg_d_q <= sgn_q && den_q[WIDTH-1];
			rem_q   <= '0;
			if (sgn_q && num_q[WIDTH-1]) begin
				num_q <= ~num_q + 1'b1;
			end
			if (sgn_q && den_q[WIDTH-1]) begin
				den_q <= ~den_q + 1'b1;
			end
		end
		if (cmd.step) begin
			rem_q <= fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
			num_q <= {num_q[WIDTH-2:0], fits};
		end
		if (cmd.fix) begin
			quo_out_q <= neg_q_res ? (~num_q + 1'b1) : num_q;
			rem_out_q <= neg_n_q ? (~rem_q + 1'b1) : rem_q;
			dz_out_q  <= dz_q;
		end
	end

	assign quotient  = quo_out_q;
	assign remainder = rem_out_q;
	assign div_zero  = dz_out_q;

endmodule

FILE: rtl/int128_divider_signed_unsigned.sv
// 128-bit signed/unsigned divider, top level; uses i128div_pkg, i128div_ctrl, i128div_dp.
// After an input item is accepted: a magnitude step, 128 shift-subtract steps of the
// shared 129-bit subtractor, then a sign fix-up that waits until the output register is free.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset: arst_n asynchronous, active low; clears controller state and output valid.
module int128_divider_signed_unsigned
	import i128div_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // dividend_hi, dividend_lo, divisor_hi, divisor_lo
	input  logic              s_axis_tuser,  // action (1 = signed)
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // quotient_hi, quotient_lo, remainder_hi, remainder_lo
	output logic              m_axis_tuser   // divide_by_zero
);

	dp_cmd_t          cmd;
	logic [WIDTH-1:0] dividend;
	logic [WIDTH-1:0] divisor;
	logic [WIDTH-1:0] quotient;
	logic [WIDTH-1:0] remainder;

	// Reassemble the 128-bit operands from their halves (high half in the low lane).
	assign dividend = {s_axis_tdata[HALF-1:0], s_axis_tdata[WIDTH-1:HALF]};
	assign divisor  = {s_axis_tdata[WIDTH+HALF-1:WIDTH],
	                   s_axis_tdata[DATA_W-1:WIDTH+HALF]};

	// Sequence one item at a time through the datapath.
	i128div_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Hold operands, run the restoring divide, fix the signs into the output register.
	i128div_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.in_signed   (s_axis_tuser),
		.in_dividend (dividend),
		.in_divisor  (divisor),
		.quotient    (quotient),
		.remainder   (remainder),
		.div_zero    (m_axis_tuser)
	);

	// Split results back into halves, high half first in the lowest bits.
	assign m_axis_tdata = {remainder[HALF-1:0], remainder[WIDTH-1:HALF],
	                       quotient[HALF-1:0], quotient[WIDTH-1:HALF]};

`ifndef ASSERT_OFF
	// Only one item is in flight: an accept drops ready in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	// A new result appears only when the fix-up stage loads the output register.
	a_valid_from_fix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.fix))
		else $error("output valid without a fix-up");

	// A zero-divisor result carries an all-ones quotient.
	a_dz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (quotient == {WIDTH{1'b1}}))
		else $error("divide by zero without all-ones quotient");

	// Datapath operations never overlap.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.absval, cmd.step, cmd.fix}))
		else $error("overlapping datapath commands");
`endif

endmodule

FILE: test/tb_int128_divider_signed_unsigned.sv
// Self-checking testbench for the 128-bit signed/unsigned divider: directed table, then
// random operands over three idle mixes, checked against a behavioral divide in the bench.
// Depends on i128div_pkg and int128_divider_signed_unsigned only.
`timescale 1ns / 100ps

module tb_int128_divider_signed_unsigned;
	import i128div_pkg::*;

	// Divide mode carried on s_axis_tuser.
	typedef enum logic {
		MODE_UNSIGNED = 1'b0,
		MODE_SIGNED   = 1'b1
	} div_mode_t;

	typedef struct packed {
		div_mode_t          mode;
		logic [WIDTH-1:0]   num;   // dividend
		logic [WIDTH-1:0]   den;   // divisor
	} div_op_t;

	typedef struct packed {
		logic [WIDTH-1:0]   quo;
		logic [WIDTH-1:0]   rem;
		logic               dbz;
	} div_res_t;

	typedef struct {
		div_op_t   op;
		bit        typed;   // expected result written into the table by hand
		div_res_t  res;
	} div_row_t;

	localparam logic [WIDTH-1:0] ONES   = {WIDTH{1'b1}};
	localparam logic [WIDTH-1:0] MIN128 = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] MAX128 = {1'b0, {(WIDTH-1){1'b1}}};

	localparam int N_RANDOM        = 1680;
	localparam int HOLDOFF_CYCLES  = 800;
	localparam int DRAIN_CYCLES    = 140;    // a little over the divider's latency for one item
	localparam int CYCLE_LIMIT     = 1200000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;    // dividend_hi, dividend_lo, divisor_hi, divisor_lo
	logic              s_axis_tuser = 1'b0;  // action (1 = signed)
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;         // quotient_hi, quotient_lo, remainder_hi, remainder_lo
	logic              m_axis_tuser;         // divide_by_zero

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        holdoff_go = 1'b0;
	logic        holdoff_done = 1'b0;
	int unsigned holdoff_cnt = 0;
	int unsigned cycle_cnt = 0;

	div_res_t    pending_q[$];     // results owed by the divider, oldest first
	div_row_t    dir_rows[$];
	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_signed = 0;
	int unsigned n_dbz = 0;
	int unsigned n_items = 0;

	int128_divider_signed_unsigned u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case the handshake hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still owed",
				$time, cycle_cnt, pending_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Two's complement truncating divide. A zero divisor returns all-ones quotient and
	// the dividend as remainder. Minimum over minus one falls out of the magnitude path:
	// both operands are negative, so 2^127 / 1 stays unnegated and reads as the minimum.
	function automatic div_res_t divide_128(input div_op_t op);
		div_res_t         res;
		logic             num_neg;
		logic             den_neg;
		logic [WIDTH-1:0] num_mag;
		logic [WIDTH-1:0] den_mag;
		logic [WIDTH-1:0] quo_mag;
		logic [WIDTH-1:0] rem_mag;
		if (op.den == '0) begin
			res.quo = ONES;
			res.rem = op.num;
			res.dbz = 1'b1;
			return res;
		end
		num_neg = (op.mode == MODE_SIGNED) && op.num[WIDTH-1];
		den_neg = (op.mode == MODE_SIGNED) && op.den[WIDTH-1];
		num_mag = num_neg ? (~op.num + 1'b1) : op.num;
		den_mag = den_neg ? (~op.den + 1'b1) : op.den;
		quo_mag = num_mag / den_mag;
		rem_mag = num_mag % den_mag;
		res.quo = (num_neg ^ den_neg) ? (~quo_mag + 1'b1) : quo_mag;
		res.rem = num_neg ? (~rem_mag + 1'b1) : rem_mag;
		res.dbz = 1'b0;
		return res;
	endfunction

	// Mostly operands of random bit length, either sign, plus corner values.
	function automatic logic [WIDTH-1:0] random_operand();
		logic [WIDTH-1:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 1;
					2: v = ONES;
					3: v = MIN128;
					4: v = MAX128;
					default: v = {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH-1);
				endcase
			end
			1, 2: ;
			default: begin
				v = v >> $urandom_range(1, WIDTH-1);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
		endcase
		return v;
	endfunction

	task automatic add_row(input div_mode_t mode, input logic [WIDTH-1:0] num,
			input logic [WIDTH-1:0] den, input bit typed,
			input logic [WIDTH-1:0] quo, input logic [WIDTH-1:0] rem, input logic dbz);
		div_row_t row;
		row.op.mode = mode;
		row.op.num  = num;
		row.op.den  = den;
		row.typed   = typed;
		row.res.quo = quo;
		row.res.rem = rem;
		row.res.dbz = dbz;
		dir_rows.push_back(row);
	endtask

	// Offer one item after a random idle stretch; hold it until the divider takes it.
	// tvalid is lowered only inside the idle loop, so back-to-back items never see a
	// low-then-high pair in the same time step.
	task automatic send_op(input div_op_t op, input div_res_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			s_axis_tuser  <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		// lowest bits first: dividend_hi, dividend_lo, divisor_hi, divisor_lo
		s_axis_tdata  <= {op.den[HALF-1:0], op.den[WIDTH-1:HALF],
			op.num[HALF-1:0], op.num[WIDTH-1:HALF]};
		s_axis_tuser  <= op.mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_q.push_back(want);
		n_items++;
		if (op.mode == MODE_SIGNED)
			n_signed++;
		if (want.dbz)
			n_dbz++;
	endtask

	// Result side: random tready, plus one long hold-off so the divider backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			holdoff_cnt   <= 0;
			holdoff_done  <= 1'b0;
		end else if (holdoff_cnt != 0) begin
			holdoff_cnt   <= holdoff_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (holdoff_go && !holdoff_done) begin
			holdoff_done  <= 1'b1;
			holdoff_cnt   <= HOLDOFF_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic report_field(input string name, input logic [WIDTH-1:0] want,
			input logic [WIDTH-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	// Compare every accepted result with the oldest one owed.
	always @(posedge clk) begin
		div_res_t want;
		div_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.quo = {m_axis_tdata[HALF-1:0], m_axis_tdata[2*HALF-1:HALF]};
			got.rem = {m_axis_tdata[3*HALF-1:2*HALF], m_axis_tdata[4*HALF-1:3*HALF]};
			got.dbz = m_axis_tuser;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got q=%h r=%h dbz=%b",
					$time, got.quo, got.rem, got.dbz);
				n_errors++;
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				report_field("quotient", want.quo, got.quo);
				report_field("remainder", want.rem, got.rem);
				report_field("divide_by_zero", WIDTH'(want.dbz), WIDTH'(got.dbz));
			end
		end
	end

	initial begin
		div_op_t  op;
		div_res_t want;
		int       k;

		// Directed rows: zero divisor, wrap case, extremes and every sign combination.
		add_row(MODE_UNSIGNED, '0,     '0,     1, ONES,   '0,     1'b1);
		add_row(MODE_UNSIGNED, ONES,   '0,     1, ONES,   ONES,   1'b1);
		add_row(MODE_SIGNED,   MIN128, '0,     1, ONES,   MIN128, 1'b1);
		add_row(MODE_SIGNED,   ONES,   '0,     1, ONES,   ONES,   1'b1);
		add_row(MODE_SIGNED,   MIN128, ONES,   1, MIN128, '0,     1'b0);
		add_row(MODE_SIGNED,   MIN128, 1,      1, MIN128, '0,     1'b0);
		add_row(MODE_SIGNED,   MIN128, MIN128, 1, 1,      '0,     1'b0);
		add_row(MODE_SIGNED,   ONES,   ONES,   1, 1,      '0,     1'b0);
		add_row(MODE_SIGNED,   MAX128, MIN128, 1, '0,     MAX128, 1'b0);
		add_row(MODE_SIGNED,   MIN128, MAX128, 1, ONES,   ONES,   1'b0);
		add_row(MODE_UNSIGNED, ONES,   1,      1, ONES,   '0,     1'b0);
		add_row(MODE_UNSIGNED, ONES,   ONES,   1, 1,      '0,     1'b0);
		add_row(MODE_UNSIGNED, '0,     ONES,   1, '0,     '0,     1'b0);
		add_row(MODE_UNSIGNED, 5,      7,      1, '0,     5,      1'b0);
		add_row(MODE_UNSIGNED, MIN128, 2,      1, MIN128 >> 1, '0, 1'b0);
		add_row(MODE_UNSIGNED, MIN128, ONES,   1, '0,     MIN128, 1'b0);
		add_row(MODE_SIGNED,   -128'sd7, 2,        1, -128'sd3, -128'sd1, 1'b0);
		add_row(MODE_SIGNED,   7,        -128'sd2, 1, -128'sd3, 1,        1'b0);
		add_row(MODE_SIGNED,   -128'sd7, -128'sd2, 1, 3,        -128'sd1, 1'b0);
		add_row(MODE_SIGNED,   MAX128, 3,      0, '0, '0, 1'b0);
		add_row(MODE_UNSIGNED, {$urandom, $urandom, $urandom, $urandom},
			{64'd0, $urandom, $urandom}, 0, '0, '0, 1'b0);
		add_row(MODE_UNSIGNED, {$urandom, $urandom, $urandom, $urandom},
			{$urandom, $urandom, 64'd0}, 0, '0, '0, 1'b0);

		// Sender quiet, receiver busy for the directed rows and first random third.
		send_idle_pct <= 6;
		recv_idle_pct <= 55;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].op,
				dir_rows[i].typed ? dir_rows[i].res : divide_128(dir_rows[i].op));

		for (k = 0; k < N_RANDOM; k++) begin
			// Swap idle mixes at each third; the last third runs flat out
			// except for the one long hold-off on the result side.
			if (k == N_RANDOM / 3) begin
				send_idle_pct <= 55;
				recv_idle_pct <= 6;
			end else if (k == 2 * N_RANDOM / 3) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
				holdoff_go    <= 1'b1;
			end
			op.mode = div_mode_t'($urandom_range(0, 1));
			op.den  = ($urandom_range(0, 49) == 0) ? '0 : random_operand();
			case ($urandom_range(0, 3))
				// quotient small by construction unless the product wraps
				0: op.num = op.den * $urandom_range(0, 1000) + random_operand() % (op.den | 1);
				default: op.num = random_operand();
			endcase
			want = divide_128(op);
			send_op(op, want);
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then give the divider time to show any stray result.
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items (%0d signed, %0d zero-divisor), %0d results compared,",
			n_items, n_signed, n_dbz, n_checked);
		$display("under three idle mixes and one %0d-cycle result hold-off.", HOLDOFF_CYCLES);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
